// ----- rtl/core/led_matrix_quarter_scan_driver_assert.svh -----
// Assertion macros for the quarter-scan LED matrix driver.
`ifndef LED_MATRIX_QUARTER_SCAN_DRIVER_ASSERT_SVH
`define LED_MATRIX_QUARTER_SCAN_DRIVER_ASSERT_SVH

`ifndef SYNTHESIS

`define LMQS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lmqs: same-cycle check failed");

`define LMQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lmqs: next-cycle check failed");

`else

`define LMQS_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`define LMQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/core/lmqs_pkg.sv -----
package lmqs_pkg;

    localparam logic [1:0] OP_PIXEL   = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;

    localparam int COLUMN_BITS_W = 4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] pixel_column;
        logic [3:0] pixel_row;
        logic       lit;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               row_select;
        logic [4:0]               column_index;
        logic [COLUMN_BITS_W-1:0] column_bits;
        logic                     latch_now;
    } t_out_item;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_mem_ctl;

endpackage

// ----- rtl/core/lmqs_stream_if.sv -----
interface lmqs_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/lmqs_store.sv -----
module lmqs_store
    import lmqs_pkg::*;
#(
    parameter int PANEL_WIDTH  = 32,
    parameter int PANEL_HEIGHT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_mem_ctl                        i_ctl,
    input  logic [$clog2(PANEL_HEIGHT)-1:0] i_rd_addr,
    input  logic [$clog2(PANEL_HEIGHT)-1:0] i_wr_addr,
    input  logic [PANEL_WIDTH-1:0]          i_wr_data,
    output logic [PANEL_WIDTH-1:0]          o_rd_data
);

    logic [PANEL_WIDTH-1:0]  r_mem [PANEL_HEIGHT];
    logic [PANEL_HEIGHT-1:0] r_row_valid;
    logic [PANEL_WIDTH-1:0]  r_rd_data;
    logic                    r_rd_valid;

    // A row that was never written since the last clear reads as dark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_ctl.clear) begin
            r_row_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_row_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_row_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ----- rtl/core/lmqs_ctrl.sv -----
module lmqs_ctrl
    import lmqs_pkg::*;
#(
    parameter int PANEL_WIDTH    = 32,
    parameter int PANEL_HEIGHT   = 16,
    parameter int SCAN_GROUPS    = 4,
    parameter int ROWS_PER_GROUP = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lmqs_stream_if.sink                     i_item,
    lmqs_stream_if.source                   o_result,
    output t_mem_ctl                        o_mem_ctl,
    output logic [$clog2(PANEL_HEIGHT)-1:0] o_rd_addr,
    output logic [$clog2(PANEL_HEIGHT)-1:0] o_wr_addr,
    output logic [PANEL_WIDTH-1:0]          o_wr_data,
    input  logic [PANEL_WIDTH-1:0]          i_rd_data
);

    localparam int RW = $clog2(PANEL_HEIGHT);
    localparam int CW = $clog2(PANEL_WIDTH);
    localparam int GW = (SCAN_GROUPS > 1) ? $clog2(SCAN_GROUPS) : 1;
    // Only the lanes that reach the column_bits field are fetched.
    localparam int NK = (ROWS_PER_GROUP < COLUMN_BITS_W) ? ROWS_PER_GROUP : COLUMN_BITS_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PIXEL = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_SEND  = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [GW-1:0]          r_group, n_group;
    logic [2:0]             r_k, n_k;
    logic [CW-1:0]          r_col, n_col;
    logic [RW-1:0]          r_pix_row;
    logic [CW-1:0]          r_pix_col;
    logic                   r_pix_lit;
    logic                   r_cap_en;
    logic                   r_cap_ok;
    logic [2:0]             r_cap_k;
    logic [PANEL_WIDTH-1:0] r_lane [NK];
    logic                   r_out_valid;
    t_out_item              r_out;

    t_in_item                 w_in;
    logic                     w_accept;
    logic                     w_pix_ok;
    logic [7:0]               w_fetch_row;
    logic                     w_fetch_ok;
    logic                     w_load;
    logic [COLUMN_BITS_W-1:0] w_bits;

    assign w_in          = i_item.payload;
    assign i_item.ready  = (r_state == S_IDLE);
    assign w_accept      = i_item.valid && i_item.ready;
    assign w_pix_ok      = (32'(w_in.pixel_column) < 32'(PANEL_WIDTH))
                        && (32'(w_in.pixel_row) < 32'(PANEL_HEIGHT));

    // Row k of the current group sits SCAN_GROUPS rows below row k-1.
    assign w_fetch_row = 8'(r_group) + 8'(r_k) * 8'(SCAN_GROUPS);
    assign w_fetch_ok  = (r_k < 3'(NK)) && (w_fetch_row < 8'(PANEL_HEIGHT));

    assign w_load = (r_state == S_SEND) && (!r_out_valid || o_result.ready);

    always_comb begin
        o_mem_ctl.rd_en = (w_accept && (w_in.opcode == OP_PIXEL) && w_pix_ok)
                       || ((r_state == S_FETCH) && w_fetch_ok);
        o_mem_ctl.wr_en = (r_state == S_PIXEL);
        o_mem_ctl.clear = w_accept && (w_in.opcode == OP_CLEAR);
        o_rd_addr       = (r_state == S_FETCH) ? RW'(w_fetch_row) : RW'(w_in.pixel_row);
        o_wr_addr       = r_pix_row;
        o_wr_data       = i_rd_data;
        o_wr_data[r_pix_col] = r_pix_lit;
    end

    always_comb begin
        n_state = r_state;
        n_group = r_group;
        n_k     = r_k;
        n_col   = r_col;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_in.opcode == OP_PIXEL) && w_pix_ok) begin
                    n_state = S_PIXEL;
                end else if (w_accept && (w_in.opcode == OP_REFRESH)) begin
                    n_state = S_FETCH;
                    n_k     = '0;
                end
            end
            S_PIXEL: begin
                n_state = S_IDLE;
            end
            S_FETCH: begin
                // One extra step lets the last row read land in its lane.
                if (r_k == 3'(NK)) begin
                    n_state = S_SEND;
                    n_col   = CW'(PANEL_WIDTH - 1);
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_SEND: begin
                if (w_load) begin
                    if (r_col == '0) begin
                        n_state = S_IDLE;
                        n_group = (r_group == GW'(SCAN_GROUPS - 1)) ? '0 : r_group + 1'b1;
                    end else begin
                        n_col = r_col - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_group     <= '0;
            r_cap_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_group  <= n_group;
            r_cap_en <= (r_state == S_FETCH) && (r_k < 3'(NK));
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_col    <= n_col;
        r_cap_ok <= w_fetch_ok;
        r_cap_k  <= r_k;
        if (w_accept) begin
            r_pix_row <= RW'(w_in.pixel_row);
            r_pix_col <= CW'(w_in.pixel_column);
            r_pix_lit <= w_in.lit;
        end
        for (int k = 0; k < NK; k++) begin
            if (r_cap_en && (r_cap_k == 3'(k))) begin
                r_lane[k] <= r_cap_ok ? i_rd_data : '0;
            end else if (w_load) begin
                r_lane[k] <= r_lane[k] << 1;
            end
        end
        if (w_load) begin
            r_out.row_select   <= 2'(r_group);
            r_out.column_index <= 5'(r_col);
            r_out.column_bits  <= w_bits;
            r_out.latch_now    <= (r_col == '0);
        end
    end

    for (genvar g = 0; g < COLUMN_BITS_W; g++) begin : g_bits
        if (g < NK) begin : g_lane
            assign w_bits[g] = r_lane[g][PANEL_WIDTH-1];
        end else begin : g_zero
            assign w_bits[g] = 1'b0;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule

// ----- rtl/core/led_matrix_quarter_scan_driver.sv -----
// Quarter-scan monochrome LED matrix driver. The frame is kept in a
// PANEL_HEIGHT x PANEL_WIDTH one-bit memory, one row per word, with a
// per-row valid bit so that reset and the clear command take effect on
// all rows together. A pixel write is a read-modify-write of one row word.
// A refresh tick reads the group's rows through the single memory read
// port, one row per cycle, into shift lanes, then sends one column result
// per cycle unless the result side stalls, from the rightmost column
// down to column 0. The last column carries latch_now, after which the
// scan group advances.
`include "led_matrix_quarter_scan_driver_assert.svh"

module led_matrix_quarter_scan_driver
    import lmqs_pkg::*;
#(
    parameter int PANEL_WIDTH    = 32,
    parameter int PANEL_HEIGHT   = 16,
    parameter int SCAN_GROUPS    = 4,
    parameter int ROWS_PER_GROUP = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lmqs_stream_if.sink   i_item,
    lmqs_stream_if.source o_result
);

    localparam int RW = $clog2(PANEL_HEIGHT);

    t_mem_ctl               w_mem_ctl;
    logic [RW-1:0]          w_rd_addr;
    logic [RW-1:0]          w_wr_addr;
    logic [PANEL_WIDTH-1:0] w_wr_data;
    logic [PANEL_WIDTH-1:0] w_rd_data;
    logic                   w_in_xfer;
    logic                   w_refresh_xfer;

    lmqs_ctrl #(
        .PANEL_WIDTH    (PANEL_WIDTH),
        .PANEL_HEIGHT   (PANEL_HEIGHT),
        .SCAN_GROUPS    (SCAN_GROUPS),
        .ROWS_PER_GROUP (ROWS_PER_GROUP)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_result  (o_result),
        .o_mem_ctl (w_mem_ctl),
        .o_rd_addr (w_rd_addr),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .i_rd_data (w_rd_data)
    );

    lmqs_store #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mem_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    assign w_in_xfer      = i_item.valid && i_item.ready;
    assign w_refresh_xfer = w_in_xfer && (i_item.payload.opcode == OP_REFRESH);

    // A row is written back only after its old contents were read.
    `LMQS_ASSERT_SAME(a_write_follows_read, i_clk, i_rst_n, w_mem_ctl.wr_en, $past(w_mem_ctl.rd_en))

    `LMQS_ASSERT_SAME(a_no_write_on_accept, i_clk, i_rst_n, w_in_xfer, !w_mem_ctl.wr_en)

    `LMQS_ASSERT_NEXT(a_busy_after_refresh, i_clk, i_rst_n, w_refresh_xfer, !i_item.ready)

endmodule
